>>> src/pts_pkg.sv
package pts_pkg;

   localparam int THREAD_SLOTS = 4;
   localparam int SLOT_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;

   localparam int KIND_W = 3;
   localparam int PRIO_W = 2;
   localparam int ENTRY_W = 64;
   localparam int STATUS_W = 3;
   localparam int SLOT_OUT_W = 6;
   localparam int LIVE_W = 7;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREAD_SLOTS - 1);

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_CREATE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_YIELD = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EXIT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SET_PRIO = 3'd3;
   localparam logic [KIND_W-1:0] KIND_START = 3'd4;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_START_REJECTED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ALL_DONE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_STARTED = 3'd4;

   typedef enum logic [1:0] {
      SLOT_FREE,
      SLOT_RUNNABLE,
      SLOT_RUNNING
   } slot_state_type;

   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic apply;
      logic report;
   } pts_cmd_type;

   typedef struct packed {
      logic scan_last;
   } pts_stat_type;

endpackage

>>> src/pts_ctrl.sv
module pts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  pts_pkg::pts_stat_type stat,
   output pts_pkg::pts_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_strobe
);
   import pts_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      APPLY,
      REPORT
   } ctrl_state_type;

   ctrl_state_type state_ff;
   logic           strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (state_ff == REPORT);
         unique case (state_ff)
            IDLE: begin
               if (start) state_ff <= SCAN;
            end
            SCAN: begin
               if (stat.scan_last) state_ff <= APPLY;
            end
            APPLY: begin
               state_ff <= REPORT;
            end
            REPORT: begin
               state_ff <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign busy          = (state_ff != IDLE);
   assign rsp_strobe    = strobe_ff;
   assign cmd.load_req  = (state_ff == IDLE) && start;
   assign cmd.scan_step = (state_ff == SCAN);
   assign cmd.apply     = (state_ff == APPLY);
   assign cmd.report    = (state_ff == REPORT);

endmodule

>>> src/pts_dpath.sv
module pts_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  pts_pkg::pts_cmd_type             cmd,
   output pts_pkg::pts_stat_type            stat,
   input  logic [pts_pkg::KIND_W-1:0]       req_kind,
   input  logic [pts_pkg::PRIO_W-1:0]       req_prio_in,
   input  logic [pts_pkg::ENTRY_W-1:0]      req_entry_address,
   output logic [pts_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_switched,
   output logic [pts_pkg::SLOT_OUT_W-1:0]   rsp_running_slot,
   output logic [pts_pkg::ENTRY_W-1:0]      rsp_running_entry,
   output logic [pts_pkg::PRIO_W-1:0]       rsp_old_priority,
   output logic [pts_pkg::PRIO_W-1:0]       rsp_current_priority
);
   import pts_pkg::*;

   // Latched request.
   logic [KIND_W-1:0]  kind_ff;
   logic [PRIO_W-1:0]  req_prio_ff;
   logic [ENTRY_W-1:0] req_entry_ff;

   // Slot table.
   slot_state_type     slot_state_ff [THREAD_SLOTS];
   slot_state_type     slot_state_in [THREAD_SLOTS];
   logic [PRIO_W-1:0]  slot_prio_ff [THREAD_SLOTS];
   logic [PRIO_W-1:0]  slot_prio_in [THREAD_SLOTS];
   logic [ENTRY_W-1:0] slot_entry_ff [THREAD_SLOTS];

   logic [SLOT_W-1:0]  sel_ff, sel_in;
   logic [LIVE_W-1:0]  live_ff, live_in;
   logic               started_ff, started_in;

   // Scan results.
   logic [SLOT_W-1:0]  scan_idx_ff;
   logic               free_found_ff;
   logic [SLOT_W-1:0]  free_idx_ff;
   logic               best_found_ff;
   logic [SLOT_W-1:0]  best_idx_ff;
   logic [PRIO_W-1:0]  best_prio_ff;

   logic [SLOT_W-1:0]   rd_idx;
   slot_state_type      rd_state;
   logic [PRIO_W-1:0]   rd_prio;

   logic [STATUS_W-1:0] status_in;
   logic                switch_in;
   logic [PRIO_W-1:0]   prev_in;

   logic [STATUS_W-1:0]   status_ff;
   logic                  switched_ff;
   logic [SLOT_OUT_W-1:0] running_slot_ff;
   logic [ENTRY_W-1:0]    running_entry_ff;
   logic [PRIO_W-1:0]     prev_prio_ff;
   logic [PRIO_W-1:0]     cur_prio_ff;

   // The table is read at one place: the scan pointer during the scan and
   // the selected slot otherwise.
   assign rd_idx   = cmd.scan_step ? scan_idx_ff : sel_ff;
   assign rd_state = slot_state_ff[rd_idx];
   assign rd_prio  = slot_prio_ff[rd_idx];

   assign stat.scan_last = (scan_idx_ff == LAST_SLOT);

   always_comb begin
      slot_state_in = slot_state_ff;
      slot_prio_in  = slot_prio_ff;
      sel_in        = sel_ff;
      live_in       = live_ff;
      started_in    = started_ff;
      status_in     = STATUS_OK;
      switch_in     = 1'b0;
      prev_in       = '0;
      priority if (kind_ff == KIND_CREATE) begin
         if (!free_found_ff) begin
            status_in = STATUS_TABLE_FULL;
         end else begin
            slot_state_in[free_idx_ff] = SLOT_RUNNABLE;
            slot_prio_in[free_idx_ff]  = req_prio_ff;
            live_in                    = live_ff + 1'b1;
         end
      end else if (kind_ff == KIND_START) begin
         if (started_ff || (live_ff == '0)) begin
            status_in = STATUS_START_REJECTED;
         end else begin
            started_in = 1'b1;
            if (best_found_ff) begin
               sel_in                     = best_idx_ff;
               slot_state_in[best_idx_ff] = SLOT_RUNNING;
               switch_in                  = 1'b1;
            end
         end
      end else if (!started_ff) begin
         status_in = STATUS_NOT_STARTED;
      end else if (kind_ff == KIND_YIELD) begin
         if (best_found_ff) begin
            if (rd_state == SLOT_RUNNING) slot_state_in[sel_ff] = SLOT_RUNNABLE;
            sel_in                     = best_idx_ff;
            slot_state_in[best_idx_ff] = SLOT_RUNNING;
         end
      end else if (kind_ff == KIND_EXIT) begin
         if (rd_state == SLOT_RUNNING) begin
            slot_state_in[sel_ff] = SLOT_FREE;
            live_in               = live_ff - 1'b1;
         end
         if (best_found_ff) begin
            sel_in                     = best_idx_ff;
            slot_state_in[best_idx_ff] = SLOT_RUNNING;
         end else if (live_in == '0) begin
            status_in = STATUS_ALL_DONE;
         end
      end else if (kind_ff == KIND_SET_PRIO) begin
         prev_in              = rd_prio;
         slot_prio_in[sel_ff] = req_prio_ff;
      end
      if (sel_in != sel_ff) switch_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            slot_state_ff[i] <= SLOT_FREE;
         end
         sel_ff        <= '0;
         live_ff       <= '0;
         started_ff    <= 1'b0;
         scan_idx_ff   <= '0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         if (cmd.load_req) begin
            scan_idx_ff   <= '0;
            free_found_ff <= 1'b0;
            best_found_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
            if ((rd_state == SLOT_FREE) && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
            if ((rd_state == SLOT_RUNNABLE) && (!best_found_ff || (rd_prio > best_prio_ff))) begin
               best_found_ff <= 1'b1;
            end
         end
         if (cmd.apply) begin
            slot_state_ff <= slot_state_in;
            sel_ff        <= sel_in;
            live_ff       <= live_in;
            started_ff    <= started_in;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff      <= req_kind;
         req_prio_ff  <= req_prio_in;
         req_entry_ff <= req_entry_address;
      end
      if (cmd.scan_step) begin
         if ((rd_state == SLOT_FREE) && !free_found_ff) begin
            free_idx_ff <= scan_idx_ff;
         end
         if ((rd_state == SLOT_RUNNABLE) && (!best_found_ff || (rd_prio > best_prio_ff))) begin
            best_idx_ff  <= scan_idx_ff;
            best_prio_ff <= rd_prio;
         end
      end
      if (cmd.apply) begin
         slot_prio_ff <= slot_prio_in;
         if ((kind_ff == KIND_CREATE) && free_found_ff) begin
            slot_entry_ff[free_idx_ff] <= req_entry_ff;
         end
         status_ff    <= status_in;
         switched_ff  <= switch_in;
         prev_prio_ff <= prev_in;
      end
      if (cmd.report) begin
         running_slot_ff  <= SLOT_OUT_W'(sel_ff);
         running_entry_ff <= started_ff ? slot_entry_ff[sel_ff] : '0;
         cur_prio_ff      <= started_ff ? rd_prio : '0;
      end
   end

   assign rsp_status           = status_ff;
   assign rsp_switched         = switched_ff;
   assign rsp_running_slot     = running_slot_ff;
   assign rsp_running_entry    = running_entry_ff;
   assign rsp_old_priority     = prev_prio_ff;
   assign rsp_current_priority = cur_prio_ff;

endmodule

>>> src/priority_thread_scheduler_top.sv
// Static-priority thread-slot scheduler.
//
// A request (kind, priority, entry address) is transferred at a rising edge
// where start is high and busy is low. The block then raises busy, scans the
// slot table one slot per cycle, applies the request and then reads back the
// selected slot. The response is presented on the rsp_ ports for exactly one
// cycle, marked by rsp_strobe, and that transfer completes at the edge ending
// the cycle; the receiver cannot hold it off. busy is already low while the
// response is shown, so a new request may be transferred in that same cycle;
// no new request is taken while an earlier one is still being processed.
// A synchronous, active-high reset marks every slot free, selects slot 0,
// clears the live count and the started flag, and leaves the block idle.
module priority_thread_scheduler_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pts_pkg::KIND_W-1:0]     req_kind,
   input  logic [pts_pkg::PRIO_W-1:0]     req_prio_in,
   input  logic [pts_pkg::ENTRY_W-1:0]    req_entry_address,
   output logic                           rsp_strobe,
   output logic [pts_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_switched,
   output logic [pts_pkg::SLOT_OUT_W-1:0] rsp_running_slot,
   output logic [pts_pkg::ENTRY_W-1:0]    rsp_running_entry,
   output logic [pts_pkg::PRIO_W-1:0]     rsp_old_priority,
   output logic [pts_pkg::PRIO_W-1:0]     rsp_current_priority
);
   import pts_pkg::*;

   pts_cmd_type  cmd;
   pts_stat_type stat;

   // The controller sequences scan, apply and report; it owns busy and the
   // response strobe.
   pts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // The datapath holds the slot table, the selection and the response
   // registers.
   pts_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_kind             (req_kind),
      .req_prio_in          (req_prio_in),
      .req_entry_address    (req_entry_address),
      .rsp_status           (rsp_status),
      .rsp_switched         (rsp_switched),
      .rsp_running_slot     (rsp_running_slot),
      .rsp_running_entry    (rsp_running_entry),
      .rsp_old_priority     (rsp_old_priority),
      .rsp_current_priority (rsp_current_priority)
   );

   // A transferred request always makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not start processing");

   // A response follows a busy cycle and is shown while the block is idle.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("response strobe outside the end of a request");

   // A change of running thread is only reported with an ok status.
   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_switched) |-> (rsp_status == STATUS_OK))
      else $error("switch reported with an error status");

   // The selected slot always lies inside the table.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_running_slot < SLOT_OUT_W'(THREAD_SLOTS)))
      else $error("running slot outside the table");

endmodule
